@@ src/facull_pkg.sv @@
// Shared types and constants for the frustum / box cull test.
// No dependencies; imported by every module of the block.
package facull_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int COEF_WIDTH  = 16;
   localparam int FRAC_BITS   = 14;
   localparam int REG_COUNT   = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;

   localparam logic [1:0] VERDICT_OUTSIDE  = 2'd0;
   localparam logic [1:0] VERDICT_STRADDLE = 2'd1;
   localparam logic [1:0] VERDICT_INSIDE   = 2'd2;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] d;
      logic signed [COEF_WIDTH-1:0] nz;
      logic signed [COEF_WIDTH-1:0] ny;
      logic signed [COEF_WIDTH-1:0] nx;
   } plane_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] box_min_x;
      logic signed [COORD_WIDTH-1:0] box_min_y;
      logic signed [COORD_WIDTH-1:0] box_min_z;
      logic signed [COORD_WIDTH-1:0] box_max_x;
      logic signed [COORD_WIDTH-1:0] box_max_y;
      logic signed [COORD_WIDTH-1:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [2:0] deciding_plane;
   } rsp_type;

endpackage

@@ src/facull_csr.sv @@
// Plane register file: one 64-bit register per stored plane, written by index.
// Planes past the register count read as zero. Depends on facull_pkg.
module facull_csr
   import facull_pkg::*;
#(
   parameter int NUM_PLANES = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output plane_type             planes [NUM_PLANES]
);

   localparam int STORED = (NUM_PLANES < REG_COUNT) ? NUM_PLANES : REG_COUNT;

   plane_type plane_ff [STORED];
   plane_type plane_in [STORED];

   always_comb begin
      for (int i = 0; i < STORED; i++) begin
         plane_in[i] = plane_ff[i];
         if (csr_wr_en && (csr_index == CSR_IDX_W'(i))) begin
            plane_in[i] = plane_type'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORED; i++) begin
            plane_ff[i] <= '0;
         end
      end else begin
         plane_ff <= plane_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_PLANES; i++) begin
         planes[i] = (i < STORED) ? plane_ff[i] : '0;
      end
   end

endmodule

@@ src/facull_plane_test.sv @@
// One plane against one box: near/far corner pick, dot products, classify.
// Pure combinational. Depends on facull_pkg.
module facull_plane_test
   import facull_pkg::*;
(
   input  plane_type  plane,
   input  req_type    box,
   output logic [1:0] result
);

   logic signed [COEF_WIDTH-1:0]  n  [3];
   logic signed [COORD_WIDTH-1:0] lo [3];
   logic signed [COORD_WIDTH-1:0] hi [3];
   logic signed [PROD_WIDTH-1:0]  pmin [3];
   logic signed [PROD_WIDTH-1:0]  pmax [3];
   logic signed [SUM_WIDTH-1:0]   min_d;
   logic signed [SUM_WIDTH-1:0]   max_d;
   logic signed [SUM_WIDTH-1:0]   neg_d;

   always_comb begin
      n[0]  = plane.nx;
      n[1]  = plane.ny;
      n[2]  = plane.nz;
      lo[0] = box.box_min_x;
      lo[1] = box.box_min_y;
      lo[2] = box.box_min_z;
      hi[0] = box.box_max_x;
      hi[1] = box.box_max_y;
      hi[2] = box.box_max_z;
      // positive normal: min corner is near; zero or negative: max corner
      for (int k = 0; k < 3; k++) begin
         if (n[k] > 0) begin
            pmin[k] = n[k] * lo[k];
            pmax[k] = n[k] * hi[k];
         end else begin
            pmin[k] = n[k] * hi[k];
            pmax[k] = n[k] * lo[k];
         end
      end
      min_d = SUM_WIDTH'(pmin[0]) + SUM_WIDTH'(pmin[1]) + SUM_WIDTH'(pmin[2]);
      max_d = SUM_WIDTH'(pmax[0]) + SUM_WIDTH'(pmax[1]) + SUM_WIDTH'(pmax[2]);
      neg_d = -(SUM_WIDTH'(plane.d) <<< FRAC_BITS);
      if (min_d > neg_d) begin
         result = VERDICT_INSIDE;
      end else if (max_d < neg_d) begin
         result = VERDICT_OUTSIDE;
      end else begin
         result = VERDICT_STRADDLE;
      end
   end

endmodule

@@ src/frustum_aabb_cull_test_core.sv @@
// Top level of the frustum / axis-aligned box cull test.
// Uses facull_pkg, facull_csr and facull_plane_test.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_data  (req_type)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data  (rsp_type)
//   csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// Two register stages: input register, then result register.
// One transaction per cycle sustained while the result side is not stalled; all plane tests run in parallel in the
// cycle between the two registers, one multiplier deep per product.
// Synchronous active-high reset clears valids and plane registers to zero.
// A stalled result holds; the input register keeps taking a transaction while
// the result register drains or is empty.
module frustum_aabb_cull_test_core
   import facull_pkg::*;
#(
   parameter int NUM_PLANES = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   plane_type  planes [NUM_PLANES];
   logic [1:0] plane_result [NUM_PLANES];

   logic    box_valid_ff, box_valid_in;
   req_type box_ff, box_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    advance;
   logic    accept;
   rsp_type result;

   facull_csr #(
      .NUM_PLANES (NUM_PLANES)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .planes    (planes)
   );

   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
      facull_plane_test u_test (
         .plane  (planes[g]),
         .box    (box_ff),
         .result (plane_result[g])
      );
   end

   // first plane that is not inside decides
   always_comb begin
      result.verdict        = VERDICT_INSIDE;
      result.deciding_plane = 3'(NUM_PLANES);
      for (int i = NUM_PLANES - 1; i >= 0; i--) begin
         if (plane_result[i] != VERDICT_INSIDE) begin
            result.verdict        = plane_result[i];
            result.deciding_plane = 3'(i);
         end
      end
   end

   assign advance   = box_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = box_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      box_valid_in = accept ? 1'b1 : (advance ? 1'b0 : box_valid_ff);
      box_in       = accept ? req_data : box_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_in = advance ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         box_valid_ff <= box_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/facull_checker.sv @@
// Port-level checks for the cull test core, attached by bind.
// Depends on facull_pkg and frustum_aabb_cull_test_core.
module facull_checker
   import facull_pkg::*;
#(
   parameter int NUM_PLANES = 6
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.verdict == VERDICT_OUTSIDE ||
                     rsp_data.verdict == VERDICT_STRADDLE ||
                     rsp_data.verdict == VERDICT_INSIDE))
      else $error("bad verdict code");

   a_inside_plane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict == VERDICT_INSIDE |->
         rsp_data.deciding_plane == 3'(NUM_PLANES))
      else $error("inside verdict with wrong plane index");

   a_deciding_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict != VERDICT_INSIDE |->
         32'(rsp_data.deciding_plane) < NUM_PLANES)
      else $error("deciding plane out of range");

endmodule

bind frustum_aabb_cull_test_core facull_checker #(
   .NUM_PLANES (NUM_PLANES)
) u_facull_checker (.*);

@@ dv/facull_verdict_monitor.sv @@
// Monitor for the frustum / box cull test: watches the request, result and csr ports,
// keeps its own copy of the plane registers, predicts each verdict and compares.
// Depends on facull_pkg.
module facull_verdict_monitor
   import facull_pkg::*;
#(
   parameter int NUM_PLANES = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_results
);

   plane_type planes [REG_COUNT];
   rsp_type   expected_verdicts [$];

   function automatic rsp_type classify_box(input req_type box);
      rsp_type   outcome;
      plane_type p;
      longint    lo [3];
      longint    hi [3];
      longint    coef [3];
      longint    near_sum;
      longint    far_sum;
      longint    bound;
      bit        decided;
      lo[0] = box.box_min_x;
      lo[1] = box.box_min_y;
      lo[2] = box.box_min_z;
      hi[0] = box.box_max_x;
      hi[1] = box.box_max_y;
      hi[2] = box.box_max_z;
      outcome.verdict        = VERDICT_INSIDE;
      outcome.deciding_plane = 3'(NUM_PLANES);
      decided = 1'b0;
      for (int i = 0; i < NUM_PLANES && !decided; i++) begin
         p = '0;
         if (i < REG_COUNT) begin
            p = planes[i];
         end
         coef[0] = p.nx;
         coef[1] = p.ny;
         coef[2] = p.nz;
         near_sum = 0;
         far_sum  = 0;
         for (int k = 0; k < 3; k++) begin
            // zero component counts as non-positive
            if (coef[k] > 0) begin
               near_sum += coef[k] * lo[k];
               far_sum  += coef[k] * hi[k];
            end else begin
               near_sum += coef[k] * hi[k];
               far_sum  += coef[k] * lo[k];
            end
         end
         bound = p.d;
         bound = -bound * (longint'(1) << FRAC_BITS);
         if (!(near_sum > bound)) begin
            decided = 1'b1;
            outcome.verdict        = (far_sum < bound) ? VERDICT_OUTSIDE : VERDICT_STRADDLE;
            outcome.deciding_plane = 3'(i);
         end
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            planes[i] = '0;
         end
         expected_verdicts.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en && csr_index < REG_COUNT) begin
            planes[csr_index] = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("result transaction with no box pending");
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, rsp_data.verdict);
                  fail_count++;
               end
               if (rsp_data.deciding_plane !== want.deciding_plane) begin
                  $error("deciding_plane: expected %0d, got %0d",
                         want.deciding_plane, rsp_data.deciding_plane);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_verdicts.push_back(classify_box(req_data));
         end
      end
      pending_results = expected_verdicts.size();
   end

endmodule

@@ dv/frustum_aabb_cull_test_core_test.sv @@
// Testbench top for frustum_aabb_cull_test_core: clock, reset, plane setup and box stimulus
// under several idle/stall mixes; verdict from facull_verdict_monitor.
// Depends on facull_pkg, the block and facull_verdict_monitor.
module frustum_aabb_cull_test_core_test;
   import facull_pkg::*;

   localparam int NUM_PLANES       = 6;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int RANDOM_PER_PHASE = 210;
   localparam int DRAIN_CYCLES     = 4;
   localparam int HOLD_CYCLES      = 80;

   localparam int PLANE_LEFT   = 0;
   localparam int PLANE_RIGHT  = 1;
   localparam int PLANE_BOTTOM = 2;
   localparam int PLANE_TOP    = 3;
   localparam int PLANE_NEAR   = 4;
   localparam int PLANE_FAR    = 5;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int        fail_count;
   int        pending_results;
   int        sender_idle_pct    = 0;
   int        receiver_stall_pct = 0;
   int        hold_request       = 0;
   int        hold_left          = 0;
   int        cycle_count        = 0;
   int        box_span           = 1000;
   plane_type frustum [REG_COUNT];

   frustum_aabb_cull_test_core #(.NUM_PLANES(NUM_PLANES)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   facull_verdict_monitor #(.NUM_PLANES(NUM_PLANES)) i_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request != 0) begin
         rsp_stall    <= 1'b1;
         hold_left    <= hold_request - 1;
         hold_request = 0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   function automatic req_type make_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
      req_type b;
      b.box_min_x = 16'(mnx);
      b.box_min_y = 16'(mny);
      b.box_min_z = 16'(mnz);
      b.box_max_x = 16'(mxx);
      b.box_max_y = 16'(mxy);
      b.box_max_z = 16'(mxz);
      return b;
   endfunction

   function automatic req_type random_box(int base_span);
      int lo [3];
      int hi [3];
      int span;
      int swap;
      if ($urandom_range(7) == 0) begin
         return req_type'({$urandom, $urandom, $urandom});
      end
      case ($urandom_range(3))
         0: span = base_span / 4 + 1;
         1: span = base_span;
         2: span = (base_span * 2 > 32767) ? 32767 : base_span * 2;
         default: span = 32767;
      endcase
      for (int k = 0; k < 3; k++) begin
         lo[k] = int'($urandom_range(2 * span)) - span;
         hi[k] = lo[k] + int'($urandom_range(span));
         if (hi[k] > 32767) begin
            hi[k] = 32767;
         end
         if ($urandom_range(15) == 0) begin
            swap  = lo[k];
            lo[k] = hi[k];
            hi[k] = swap;
         end
      end
      return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   function automatic plane_type axis_plane(int axis, int sign, int mag, int reach, int tilt);
      plane_type p;
      int        n [3];
      for (int k = 0; k < 3; k++) begin
         n[k] = (k == axis) ? sign * mag : int'($urandom_range(2 * tilt)) - tilt;
      end
      p.nx = 16'(n[0]);
      p.ny = 16'(n[1]);
      p.nz = 16'(n[2]);
      p.d  = 16'(reach);
      return p;
   endfunction

   // box-shaped frustum: the region |coordinate| < reach * 2**FRAC_BITS / mag on each axis when untilted
   task automatic build_box_frustum(int mag, int reach, int tilt);
      frustum[PLANE_LEFT]   = axis_plane(0, 1, mag, reach, tilt);
      frustum[PLANE_RIGHT]  = axis_plane(0, -1, mag, reach, tilt);
      frustum[PLANE_BOTTOM] = axis_plane(1, 1, mag, reach, tilt);
      frustum[PLANE_TOP]    = axis_plane(1, -1, mag, reach, tilt);
      frustum[PLANE_NEAR]   = axis_plane(2, 1, mag, reach, tilt);
      frustum[PLANE_FAR]    = axis_plane(2, -1, mag, reach, tilt);
      box_span = reach;
   endtask

   task automatic load_frustum();
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= frustum[i];
         @(posedge clock);
      end
      // unmapped indexes, must be ignored
      for (int i = REG_COUNT; i < (1 << CSR_IDX_W); i++) begin
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_box(input req_type box);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= box;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // planes at reset value: every box straddles the first plane
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      drain_results();

      build_box_frustum(16384, 1000, 0);
      load_frustum();
      send_box(make_box(-10, -10, -10, 10, 10, 10));
      send_box(make_box(-999, -999, -999, 999, 999, 999));
      send_box(make_box(-1000, 0, 0, 0, 0, 0));
      send_box(make_box(-2000, 0, 0, -1001, 0, 0));
      send_box(make_box(-2000, 0, 0, -1000, 0, 0));
      send_box(make_box(500, 0, 0, 2000, 0, 0));
      send_box(make_box(1001, 0, 0, 1500, 0, 0));
      send_box(make_box(0, -1500, 0, 0, -1200, 0));
      send_box(make_box(0, 0, 0, 0, 1000, 0));
      send_box(make_box(0, 0, -5000, 0, 0, 0));
      send_box(make_box(0, 0, 1200, 0, 0, 1300));
      send_box(make_box(0, 0, 999, 0, 0, 1000));
      send_box(make_box(10, 10, 10, -10, -10, -10));
      send_box(make_box(1500, 0, 0, -1500, 0, 0));
      send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
      drain_results();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               build_box_frustum(int'($urandom_range(8192, 32767)),
                                 int'($urandom_range(300, 5000)), 2000);
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               frustum[PLANE_LEFT]   = 64'h7FFF_7FFF_7FFF_7FFF;
               frustum[PLANE_RIGHT]  = 64'h8000_8000_8000_8000;
               frustum[PLANE_BOTTOM] = 64'hFFFF_FFFF_FFFF_FFFF;
               frustum[PLANE_TOP]    = 64'h7FFF_8000_7FFF_8000;
               frustum[PLANE_NEAR]   = 64'h8000_0001_C000_4000;
               frustum[PLANE_FAR]    = 64'h0000_0000_0000_0000;
               box_span           = 2000;
               sender_idle_pct    = 50;
               receiver_stall_pct = 0;
            end
            2: begin
               for (int i = 0; i < REG_COUNT; i++) begin
                  frustum[i] = {$urandom, $urandom};
               end
               box_span           = 2000;
               sender_idle_pct    = 0;
               receiver_stall_pct = 50;
            end
            3: begin
               build_box_frustum(32767, int'($urandom_range(300, 20000)), 0);
               sender_idle_pct    = 31;
               receiver_stall_pct = 31;
            end
            default: begin
               build_box_frustum(int'($urandom_range(4096, 32767)),
                                 int'($urandom_range(300, 5000)), 500);
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         load_frustum();
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 4 && n == 20) begin
               hold_request = HOLD_CYCLES;
            end
            send_box(random_box(box_span));
         end
         drain_results();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
